[hw/rtl/rmtc_pkg.sv]
package rmtc_pkg;

    // Field widths fixed by the item format
    localparam int unsigned POS_W      = 32;
    localparam int unsigned RPM_W      = 16;
    localparam int unsigned GEAR_W     = 4;
    localparam int unsigned IND_W      = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned HALF_W     = POS_W / 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEATURE_ENABLE = 2'd0,
        CFG_PARK_POSITIONS = 2'd1,
        CFG_RPM_THRESHOLD  = 2'd2
    } t_cfg_idx;

    // Gear codes
    localparam logic [GEAR_W-1:0] GEAR_REVERSE = 4'he;
    localparam logic [GEAR_W-1:0] GEAR_PARK    = 4'hd;
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 4'h0;

    // Indicator codes
    localparam logic [IND_W-1:0] IND_LEFT  = 2'd2;
    localparam logic [IND_W-1:0] IND_RIGHT = 2'd1;

    // Reset values
    localparam logic [RPM_W-1:0] RPM_THRESHOLD_RST = 16'd400;

    // Timing limits in milliseconds
    localparam int unsigned STALE_LIMIT    = 1000;
    localparam int unsigned NEUTRAL_SETTLE = 500;
    localparam int unsigned EXIT_LIMIT     = 10000;
    localparam int unsigned RESTORE_LIMIT  = 17500;
    localparam int unsigned CHANGE_HOLDOFF = 2500;
    localparam int unsigned SEND_PERIOD    = 900;

endpackage

[hw/rtl/rmtc_in_if.sv]
interface rmtc_in_if #(
    parameter int unsigned TIME_WIDTH = 32
);
    import rmtc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] now;
    logic                  gear_valid;
    logic                  rpm_valid;
    logic [TIME_WIDTH-1:0] gear_stamp;
    logic [TIME_WIDTH-1:0] rpm_stamp;
    logic [GEAR_W-1:0]     gear;
    logic [RPM_W-1:0]      rpm;
    logic [IND_W-1:0]      indicator;
    logic                  capture_done;
    logic [POS_W-1:0]      operative_positions;
    logic                  tx_ready;

    modport source (
        output valid, now, gear_valid, rpm_valid, gear_stamp, rpm_stamp, gear, rpm,
               indicator, capture_done, operative_positions, tx_ready,
        input  ready
    );

    modport sink (
        input  valid, now, gear_valid, rpm_valid, gear_stamp, rpm_stamp, gear, rpm,
               indicator, capture_done, operative_positions, tx_ready,
        output ready
    );

endinterface

[hw/rtl/rmtc_out_if.sv]
interface rmtc_out_if;
    import rmtc_pkg::*;

    logic             valid;
    logic             ready;
    logic             send_frame;
    logic [POS_W-1:0] frame_positions;
    logic             left_lowered;
    logic             right_lowered;
    logic             restoring;
    logic             capture_request;

    modport source (
        output valid, send_frame, frame_positions, left_lowered, right_lowered,
               restoring, capture_request,
        input  ready
    );

    modport sink (
        input  valid, send_frame, frame_positions, left_lowered, right_lowered,
               restoring, capture_request,
        output ready
    );

endinterface

[hw/rtl/reverse_mirror_tilt_controller.sv]
// Reverse mirror tilt controller.
//
// i_in carries one tick per transaction: time, gear and rpm readings with
// their arrival stamps, turn indicator, operative mirror positions, the
// capture-done flag and the transmit-ready flag. o_out returns exactly one
// result transaction per tick: frame send flag and positions, the lowered
// state of each mirror, the restore flag and the capture request.
// Configuration (feature enable, park positions, rpm threshold) is written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only
// while no tick is in flight, as the block itself does not enforce this.
// Path: an accepted tick is registered in the input stage, evaluated
// combinationally against the controller state, and its result is loaded
// into the result register, which presents it on o_out.
// Throughput: one tick per cycle while o_out does not stall; the single
// evaluation stage updates the state in the same cycle it produces the
// result, so back-to-back ticks see each other's effects.
// Reset clears all controller state and restores the configuration defaults
// (feature off, park positions zero, threshold 400). When o_out stalls, the
// result register holds, the evaluation stage holds its tick and i_in
// drops ready once both are full; nothing is lost or repeated.
module reverse_mirror_tilt_controller #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rmtc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rmtc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rmtc_in_if.sink                            i_in,
    rmtc_out_if.source                         o_out
);
    import rmtc_pkg::*;

    typedef logic [TIME_WIDTH-1:0] t_time;

    // Configuration registers
    logic             r_feature_en;
    logic [POS_W-1:0] r_park_pos;
    logic [RPM_W-1:0] r_rpm_thr;

    // Input stage
    logic             r_s1_valid;
    t_time            r_s1_now;
    logic             r_s1_gear_valid;
    logic             r_s1_rpm_valid;
    t_time            r_s1_gear_stamp;
    t_time            r_s1_rpm_stamp;
    logic [GEAR_W-1:0] r_s1_gear;
    logic [RPM_W-1:0] r_s1_rpm;
    logic [IND_W-1:0] r_s1_ind;
    logic             r_s1_cap_done;
    logic [POS_W-1:0] r_s1_oper;
    logic             r_s1_tx_ready;

    // Controller state
    logic  r_left_req,  n_left_req;
    logic  r_right_req, n_right_req;
    logic  r_restore,   n_restore;
    logic  r_capture,   n_capture;
    logic  r_exit,      n_exit;
    logic  r_neutral,   n_neutral;
    t_time r_restore_t, n_restore_t;
    t_time r_exit_t,    n_exit_t;
    t_time r_neutral_t, n_neutral_t;
    t_time r_change_t,  n_change_t;
    t_time r_last_send, n_last_send;

    // Result register
    logic             r_out_valid;
    logic             r_out_send;
    logic [POS_W-1:0] r_out_frame;
    logic             r_out_left;
    logic             r_out_right;
    logic             r_out_restore;
    logic             r_out_capture;

    logic             n_send;
    logic [POS_W-1:0] n_frame;

    logic             w_in_accept;
    logic             w_advance;
    logic             w_fresh;
    logic             w_reverse;
    logic             w_immediate;
    logic             w_neutral_gear;
    logic             w_sel_left;
    logic             w_sel_right;
    logic             v_lowered;
    logic [POS_W-1:0] v_lsrc;
    logic [POS_W-1:0] v_rsrc;

    // Handshake: the evaluation stage advances when the result register is
    // free or being drained this cycle.
    assign w_advance   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_advance;
    assign w_in_accept = i_in.valid && i_in.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_en <= 1'b0;
            r_park_pos   <= '0;
            r_rpm_thr    <= RPM_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FEATURE_ENABLE: r_feature_en <= i_cfg_data[0];
                CFG_PARK_POSITIONS: r_park_pos   <= i_cfg_data[POS_W-1:0];
                CFG_RPM_THRESHOLD:  r_rpm_thr    <= i_cfg_data[RPM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: capture a tick on accept, drop it once evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_now        <= i_in.now;
            r_s1_gear_valid <= i_in.gear_valid;
            r_s1_rpm_valid  <= i_in.rpm_valid;
            r_s1_gear_stamp <= i_in.gear_stamp;
            r_s1_rpm_stamp  <= i_in.rpm_stamp;
            r_s1_gear       <= i_in.gear;
            r_s1_rpm        <= i_in.rpm;
            r_s1_ind        <= i_in.indicator;
            r_s1_cap_done   <= i_in.capture_done;
            r_s1_oper       <= i_in.operative_positions;
            r_s1_tx_ready   <= i_in.tx_ready;
        end
    end

    // Tick qualification: both readings present and no older than the limit
    assign w_fresh = r_s1_gear_valid && r_s1_rpm_valid
                  && ((r_s1_now - r_s1_gear_stamp) <= TIME_WIDTH'(STALE_LIMIT))
                  && ((r_s1_now - r_s1_rpm_stamp)  <= TIME_WIDTH'(STALE_LIMIT));

    assign w_reverse      = r_feature_en && (r_s1_gear == GEAR_REVERSE)
                         && (r_s1_rpm > r_rpm_thr);
    assign w_immediate    = !r_feature_en || (r_s1_gear == GEAR_PARK)
                         || (r_s1_rpm <= r_rpm_thr);
    assign w_neutral_gear = (r_s1_gear == GEAR_NEUTRAL);
    assign w_sel_left     = (r_s1_ind == IND_LEFT);
    assign w_sel_right    = (r_s1_ind == IND_RIGHT);

    // Evaluate one tick against the controller state
    always_comb begin
        n_left_req  = r_left_req;
        n_right_req = r_right_req;
        n_restore   = r_restore;
        n_capture   = r_capture && !r_s1_cap_done;
        n_exit      = r_exit;
        n_neutral   = r_neutral;
        n_restore_t = r_restore_t;
        n_exit_t    = r_exit_t;
        n_neutral_t = r_neutral_t;
        n_change_t  = r_change_t;
        n_last_send = r_last_send;
        n_send      = 1'b0;
        n_frame     = '0;
        v_lowered   = r_left_req || r_right_req;
        v_lsrc      = r_s1_oper;
        v_rsrc      = r_s1_oper;

        if (w_fresh) begin
            if (w_reverse) begin
                n_exit    = 1'b0;
                n_neutral = 1'b0;
                // Lower the indicated side on its first request
                if ((w_sel_left && !r_left_req) || (w_sel_right && !r_right_req)) begin
                    if (!v_lowered && !r_restore) begin
                        n_capture = 1'b1;
                    end
                    n_restore = 1'b0;
                    if (w_sel_left) begin
                        n_left_req = 1'b1;
                    end else begin
                        n_right_req = 1'b1;
                    end
                    n_change_t = r_s1_now;
                    v_lowered  = 1'b1;
                end
            end else if (v_lowered) begin
                // Left reverse: track exit and settled neutral timers, restore on release
                if (!r_exit) begin
                    n_exit   = 1'b1;
                    n_exit_t = r_s1_now;
                end
                if (w_neutral_gear && !r_neutral) begin
                    n_neutral   = 1'b1;
                    n_neutral_t = r_s1_now;
                end
                if (!w_neutral_gear) begin
                    n_neutral = 1'b0;
                end
                if (w_immediate
                        || (n_neutral && ((r_s1_now - n_neutral_t)
                                          >= TIME_WIDTH'(NEUTRAL_SETTLE)))
                        || ((r_s1_now - n_exit_t) >= TIME_WIDTH'(EXIT_LIMIT))) begin
                    n_left_req  = 1'b0;
                    n_right_req = 1'b0;
                    n_restore   = 1'b1;
                    n_restore_t = r_s1_now;
                    n_change_t  = r_s1_now;
                    v_lowered   = 1'b0;
                    n_exit      = 1'b0;
                    n_neutral   = 1'b0;
                end
            end

            // End the restore window
            if (n_restore && ((r_s1_now - n_restore_t) > TIME_WIDTH'(RESTORE_LIMIT))) begin
                n_restore = 1'b0;
            end

            // Frame emission under holdoff and period rules
            if ((v_lowered || n_restore) && !n_capture
                    && ((r_s1_now - n_change_t)  >= TIME_WIDTH'(CHANGE_HOLDOFF))
                    && ((r_s1_now - r_last_send) >= TIME_WIDTH'(SEND_PERIOD))
                    && r_s1_tx_ready) begin
                v_lsrc      = n_left_req  ? r_park_pos : r_s1_oper;
                v_rsrc      = n_right_req ? r_park_pos : r_s1_oper;
                n_frame     = {v_rsrc[POS_W-1:HALF_W], v_lsrc[HALF_W-1:0]};
                n_send      = 1'b1;
                n_last_send = r_s1_now;
            end
        end
    end

    // Commit state when the tick advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_req  <= 1'b0;
            r_right_req <= 1'b0;
            r_restore   <= 1'b0;
            r_capture   <= 1'b0;
            r_exit      <= 1'b0;
            r_neutral   <= 1'b0;
            r_restore_t <= '0;
            r_exit_t    <= '0;
            r_neutral_t <= '0;
            r_change_t  <= '0;
            r_last_send <= '0;
        end else if (w_advance) begin
            r_left_req  <= n_left_req;
            r_right_req <= n_right_req;
            r_restore   <= n_restore;
            r_capture   <= n_capture;
            r_exit      <= n_exit;
            r_neutral   <= n_neutral;
            r_restore_t <= n_restore_t;
            r_exit_t    <= n_exit_t;
            r_neutral_t <= n_neutral_t;
            r_change_t  <= n_change_t;
            r_last_send <= n_last_send;
        end
    end

    // Result register: load on advance, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_send    <= n_send;
            r_out_frame   <= n_frame;
            r_out_left    <= n_left_req;
            r_out_right   <= n_right_req;
            r_out_restore <= n_restore;
            r_out_capture <= n_capture;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.send_frame      = r_out_send;
    assign o_out.frame_positions = r_out_frame;
    assign o_out.left_lowered    = r_out_left;
    assign o_out.right_lowered   = r_out_right;
    assign o_out.restoring       = r_out_restore;
    assign o_out.capture_request = r_out_capture;

    // A frame never goes out while a capture is still pending
    a_no_send_with_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_send && r_out_capture))
        else $error("frame sent while capture pending");

    // Frame positions are zero whenever no frame is sent
    a_frame_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_send) |-> (r_out_frame == '0))
        else $error("frame positions nonzero without send");

    // Restoring and lowered mirrors exclude each other
    a_restore_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_restore |-> !(r_left_req || r_right_req))
        else $error("restore active while a mirror is lowered");

    // A stalled tick keeps its place in the evaluation stage
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> r_s1_valid)
        else $error("evaluation stage lost a tick");

    // State only changes when a tick is evaluated
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_advance && $past(i_rst_n)) |=> $stable(r_last_send) && $stable(r_change_t))
        else $error("controller state moved without a tick");

endmodule
